FILE: hw/rtl/stq_pkg.sv
`default_nettype none
package stq_pkg;

   // field widths of the request and response transfers
   localparam int TIME_W = 48;
   localparam int IV_W = 32;
   localparam int ID_W = 16;
   localparam int POS_W = 6;

   // parameter defaults
   localparam int DEPTH_DEF = 16;
   localparam int ID_BITS_DEF = 16;

   // request codes
   typedef enum logic [1:0] {
      REQ_ADD = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_TICK = 2'd2,
      REQ_NONE = 2'd3
   } req_type_type;

   // response status codes
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_FULL = 3'd1,
      ST_CANCELLED = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EXPIRED = 3'd4,
      ST_TICK_DONE = 3'd5
   } status_type;

   // entry store operations
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_INS = 2'd1,
      CELL_REM = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [POS_W-1:0] pos;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/stq_ram.sv
`default_nettype none
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(DEPTH)-1:0] waddr,
   input wire logic [WIDTH-1:0] wdata,
   input wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/stq_cells.sv
`default_nettype none
module stq_cells #(
   parameter int DEPTH = stq_pkg::DEPTH_DEF,
   parameter int KW = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire stq_pkg::cell_ctl_type ctl,
   input wire logic [stq_pkg::TIME_W-1:0] wr_expiry,
   input wire logic [stq_pkg::IV_W-1:0] wr_interval,
   input wire logic [KW-1:0] wr_ident,
   input wire logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic [stq_pkg::TIME_W-1:0] rd_expiry,
   output logic [stq_pkg::IV_W-1:0] rd_interval,
   output logic [KW-1:0] rd_ident,
   output logic [stq_pkg::TIME_W-1:0] head_expiry,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [stq_pkg::TIME_W-1:0] exp_ff [DEPTH];
   logic [stq_pkg::IV_W-1:0] iv_ff [DEPTH];
   logic [KW-1:0] id_ff [DEPTH];
   logic [stq_pkg::TIME_W-1:0] exp_in [DEPTH];
   logic [stq_pkg::IV_W-1:0] iv_in [DEPTH];
   logic [KW-1:0] id_in [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos;

   assign pos = ctl.pos[IW-1:0];

   // each cell takes its own value, its left or right neighbour, or the new entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         exp_in[i] = exp_ff[i];
         iv_in[i] = iv_ff[i];
         id_in[i] = id_ff[i];
         unique case (ctl.op)
            stq_pkg::CELL_INS: begin
               if (IW'(i) == pos) begin
                  exp_in[i] = wr_expiry;
                  iv_in[i] = wr_interval;
                  id_in[i] = wr_ident;
               end else if (IW'(i) > pos && i > 0) begin
                  exp_in[i] = exp_ff[(i > 0) ? i-1 : 0];
                  iv_in[i] = iv_ff[(i > 0) ? i-1 : 0];
                  id_in[i] = id_ff[(i > 0) ? i-1 : 0];
               end
            end
            stq_pkg::CELL_REM: begin
               if (IW'(i) >= pos && i < DEPTH-1) begin
                  exp_in[i] = exp_ff[(i < DEPTH-1) ? i+1 : i];
                  iv_in[i] = iv_ff[(i < DEPTH-1) ? i+1 : i];
                  id_in[i] = id_ff[(i < DEPTH-1) ? i+1 : i];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // fill count
   always_comb begin
      unique case (ctl.op)
         stq_pkg::CELL_INS: count_in = count_ff + 1'b1;
         stq_pkg::CELL_REM: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         exp_ff[i] <= exp_in[i];
         iv_ff[i] <= iv_in[i];
         id_ff[i] <= id_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // read port at the scan position
   always_comb begin
      rd_expiry = '0;
      rd_interval = '0;
      rd_ident = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (IW'(i) == rd_idx) begin
            rd_expiry = exp_ff[i];
            rd_interval = iv_ff[i];
            rd_ident = id_ff[i];
         end
      end
   end

   assign head_expiry = exp_ff[0];
   assign count = count_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/sorted_timer_queue.sv
// add and cancel scan the entries from the front; an add to a full queue goes straight to the result
// tick: pops expired timers, reads each back and rescans to re-insert it if it repeats,
// then reports each expired id and ends with the summary
// throughput: one request at a time, busy stays high until the last result
// results are strobed for one cycle each and cannot be held off
// synchronous active-high reset empties the queue; entry contents are not cleared
`default_nettype none
module sorted_timer_queue #(
   parameter int DEPTH = stq_pkg::DEPTH_DEF,
   parameter int ID_BITS = stq_pkg::ID_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_type,
   input wire logic [stq_pkg::ID_W-1:0] req_timer_id,
   input wire logic [stq_pkg::TIME_W-1:0] req_expire_time,
   input wire logic [stq_pkg::IV_W-1:0] req_interval_us,
   output logic rsp_strobe,
   output logic [2:0] rsp_status,
   output logic [stq_pkg::ID_W-1:0] rsp_out_id,
   output logic rsp_head_changed,
   output logic [stq_pkg::TIME_W-1:0] rsp_next_expiry,
   output logic rsp_queue_empty,
   output logic rsp_last
);

   localparam int KW = (ID_BITS < stq_pkg::ID_W) ? ID_BITS : stq_pkg::ID_W;
   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int TW = stq_pkg::TIME_W;
   localparam int VW = stq_pkg::IV_W;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_ADD_SCAN = 10'b0000000010,
      S_CAN_SCAN = 10'b0000000100,
      S_TK_POP = 10'b0000001000,
      S_RI_RD = 10'b0000010000,
      S_RI_CHK = 10'b0000100000,
      S_RI_SCAN = 10'b0001000000,
      S_EMIT_RD = 10'b0010000000,
      S_EMIT = 10'b0100000000,
      S_RESP = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in, n_ff, n_in, k_ff, k_in;
   logic [TW-1:0] key_ff, key_in, now_ff, now_in;
   logic [KW-1:0] id_ff, id_in;
   logic [VW-1:0] iv_ff, iv_in;
   stq_pkg::status_type sts_ff, sts_in;
   logic head_ff, head_in, sum_ff, sum_in;

   stq_pkg::cell_ctl_type ctl;
   logic [TW-1:0] rd_expiry, head_expiry, cmp_b;
   logic [VW-1:0] rd_interval;
   logic [KW-1:0] rd_ident;
   logic [CW-1:0] count;
   logic [IW-1:0] rd_idx;
   logic ram_we;
   logic [KW+VW-1:0] ram_rdata;
   logic [IW-1:0] ram_raddr;
   logic cmp_le, cmp_lt, cmp_eq, in_range;
   logic [TW:0] sum_wide;
   logic [TW-1:0] sum_sat;
   logic [CW-1:0] k_inc;

   // shared compare unit: scan entry against key or current time
   assign rd_idx = (state_ff == S_TK_POP) ? '0 : idx_ff[IW-1:0];
   assign cmp_b = (state_ff == S_TK_POP) ? now_ff : key_ff;
   assign cmp_le = rd_expiry <= cmp_b;
   assign cmp_lt = rd_expiry < cmp_b;
   assign cmp_eq = rd_ident == id_ff;
   assign in_range = idx_ff < count;

   // repeat expiry, saturating at all ones
   assign sum_wide = {1'b0, now_ff} + (TW+1)'(ram_rdata[VW-1:0]);
   assign sum_sat = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
   assign k_inc = k_ff + 1'b1;

   assign ram_raddr = k_ff[IW-1:0];
   assign ram_we = (state_ff == S_TK_POP) && (count != '0) && cmp_lt;

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      k_in = k_ff;
      key_in = key_ff;
      now_in = now_ff;
      id_in = id_ff;
      iv_in = iv_ff;
      sts_in = sts_ff;
      head_in = head_ff;
      sum_in = sum_ff;
      ctl.op = stq_pkg::CELL_HOLD;
      ctl.pos = stq_pkg::POS_W'(idx_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in = req_timer_id[KW-1:0];
               key_in = req_expire_time;
               now_in = req_expire_time;
               iv_in = req_interval_us;
               idx_in = '0;
               n_in = '0;
               head_in = 1'b0;
               sum_in = 1'b0;
               unique case (stq_pkg::req_type_type'(req_type))
                  stq_pkg::REQ_ADD: begin
                     if (count >= CW'(DEPTH)) begin
                        sts_in = stq_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_ADD_SCAN;
                     end
                  end
                  stq_pkg::REQ_CANCEL: state_in = S_CAN_SCAN;
                  stq_pkg::REQ_TICK: state_in = S_TK_POP;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_SCAN: begin
            if (in_range && cmp_le) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               ctl.op = stq_pkg::CELL_INS;
               head_in = (idx_ff == '0);
               sts_in = stq_pkg::ST_INSERTED;
               state_in = S_RESP;
            end
         end
         S_CAN_SCAN: begin
            if (!in_range) begin
               sts_in = stq_pkg::ST_NOT_FOUND;
               state_in = S_RESP;
            end else if (cmp_eq) begin
               ctl.op = stq_pkg::CELL_REM;
               sts_in = stq_pkg::ST_CANCELLED;
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TK_POP: begin
            ctl.pos = '0;
            k_in = '0;
            if (count != '0 && cmp_lt) begin
               ctl.op = stq_pkg::CELL_REM;
               n_in = n_ff + 1'b1;
            end else if (n_ff == '0) begin
               sts_in = stq_pkg::ST_TICK_DONE;
               sum_in = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_RI_RD;
            end
         end
         S_RI_RD: begin
            state_in = S_RI_CHK;
         end
         S_RI_CHK: begin
            idx_in = '0;
            key_in = sum_sat;
            id_in = ram_rdata[KW+VW-1:VW];
            iv_in = ram_rdata[VW-1:0];
            if (ram_rdata[VW-1:0] != '0) begin
               state_in = S_RI_SCAN;
            end else if (k_inc == n_ff) begin
               k_in = '0;
               state_in = S_EMIT_RD;
            end else begin
               k_in = k_inc;
               state_in = S_RI_RD;
            end
         end
         S_RI_SCAN: begin
            if (in_range && cmp_le) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               ctl.op = stq_pkg::CELL_INS;
               if (idx_ff == '0) begin
                  head_in = 1'b1;
               end
               if (k_inc == n_ff) begin
                  k_in = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  k_in = k_inc;
                  state_in = S_RI_RD;
               end
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            k_in = k_inc;
            if (k_inc == n_ff) begin
               sts_in = stq_pkg::ST_TICK_DONE;
               sum_in = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      n_ff <= n_in;
      k_ff <= k_in;
      key_ff <= key_in;
      now_ff <= now_in;
      id_ff <= id_in;
      iv_ff <= iv_in;
      sts_ff <= sts_in;
      head_ff <= head_in;
      sum_ff <= sum_in;
   end

   stq_cells #(
      .DEPTH(DEPTH),
      .KW(KW)
   ) u_cells (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .wr_expiry(key_ff),
      .wr_interval(iv_ff),
      .wr_ident(id_ff),
      .rd_idx(rd_idx),
      .rd_expiry(rd_expiry),
      .rd_interval(rd_interval),
      .rd_ident(rd_ident),
      .head_expiry(head_expiry),
      .count(count)
   );

   // expired timers waiting for re-insertion and reporting
   stq_ram #(
      .WIDTH(KW+VW),
      .DEPTH(DEPTH)
   ) u_expired (
      .clock(clock),
      .we(ram_we),
      .waddr(n_ff[IW-1:0]),
      .wdata({rd_ident, rd_interval}),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // response transfer
   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP) || (state_ff == S_EMIT);
   assign rsp_last = (state_ff == S_RESP);
   assign rsp_status = (state_ff == S_EMIT) ? stq_pkg::ST_EXPIRED : sts_ff;
   assign rsp_out_id = (state_ff == S_EMIT) ? stq_pkg::ID_W'(ram_rdata[KW+VW-1:VW])
                     : (sum_ff ? '0 : stq_pkg::ID_W'(id_ff));
   assign rsp_head_changed = (state_ff == S_RESP) && head_ff;
   assign rsp_queue_empty = (count == '0);
   assign rsp_next_expiry = (count == '0) ? '0 : head_expiry;

`ifndef SYNTH
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result strobe while idle");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy) else $error("busy after last result");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(DEPTH)) else $error("fill count beyond depth");
   a_unused_code: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == 2'd3 |=> !busy) else $error("unused request taken");
`endif

endmodule
`default_nettype wire

FILE: bench/stq_checker.sv
`default_nettype none
module stq_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic [1:0] req_type,
   input wire logic [stq_pkg::ID_W-1:0] req_timer_id,
   input wire logic [stq_pkg::TIME_W-1:0] req_expire_time,
   input wire logic [stq_pkg::IV_W-1:0] req_interval_us,
   input wire logic rsp_strobe,
   input wire logic [2:0] rsp_status,
   input wire logic [stq_pkg::ID_W-1:0] rsp_out_id,
   input wire logic rsp_head_changed,
   input wire logic [stq_pkg::TIME_W-1:0] rsp_next_expiry,
   input wire logic rsp_queue_empty,
   input wire logic rsp_last,
   output int fail_count,
   output int pending_count
);

   localparam int DEPTH = stq_pkg::DEPTH_DEF;
   localparam int TIME_W = stq_pkg::TIME_W;
   localparam int IV_W = stq_pkg::IV_W;
   localparam int ID_W = stq_pkg::ID_W;
   localparam int RING_LEN = 64;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [2:0] status;
      logic [ID_W-1:0] out_id;
      logic head_changed;
      logic [TIME_W-1:0] next_expiry;
      logic queue_empty;
      logic last;
   } timer_rsp_type;

   // model copy of the timer list
   logic [TIME_W-1:0] q_exp [DEPTH];
   logic [IV_W-1:0] q_iv [DEPTH];
   logic [ID_W-1:0] q_id [DEPTH];
   int q_cnt;

   // expected results waiting for their transfer
   timer_rsp_type rsp_ring [RING_LEN];
   int wr_ptr;
   int rd_ptr;

   assign pending_count = wr_ptr - rd_ptr;

   // stable insert, returns 1 when placed at the front
   function automatic bit insert_timer(logic [TIME_W-1:0] e, logic [IV_W-1:0] v,
                                       logic [ID_W-1:0] d);
      int p;
      p = 0;
      while (p < q_cnt && q_exp[p] <= e) p++;
      for (int i = q_cnt; i > p; i--) begin
         q_exp[i] = q_exp[i-1];
         q_iv[i] = q_iv[i-1];
         q_id[i] = q_id[i-1];
      end
      q_exp[p] = e;
      q_iv[p] = v;
      q_id[p] = d;
      q_cnt++;
      return p == 0;
   endfunction

   function automatic void push_rsp(stq_pkg::status_type s, logic [ID_W-1:0] d,
                                    bit h, bit l);
      timer_rsp_type r;
      r.status = s;
      r.out_id = d;
      r.head_changed = h;
      r.next_expiry = q_cnt != 0 ? q_exp[0] : '0;
      r.queue_empty = q_cnt == 0;
      r.last = l;
      rsp_ring[wr_ptr % RING_LEN] = r;
      wr_ptr++;
   endfunction

   function automatic void predict_request(logic [1:0] t, logic [ID_W-1:0] d,
                                           logic [TIME_W-1:0] tm, logic [IV_W-1:0] v);
      logic [ID_W-1:0] xid [DEPTH];
      logic [IV_W-1:0] xiv [DEPTH];
      logic [TIME_W:0] sum;
      int n;
      int f;
      bit front;
      front = 0;
      n = 0;
      unique case (t)
         stq_pkg::REQ_ADD: begin
            if (q_cnt >= DEPTH) push_rsp(stq_pkg::ST_FULL, d, 0, 1);
            else begin
               front = insert_timer(tm, v, d);
               push_rsp(stq_pkg::ST_INSERTED, d, front, 1);
            end
         end
         stq_pkg::REQ_CANCEL: begin
            f = -1;
            for (int i = 0; i < q_cnt; i++)
               if (f < 0 && q_id[i] == d) f = i;
            if (f >= 0) begin
               for (int i = f; i + 1 < q_cnt; i++) begin
                  q_exp[i] = q_exp[i+1];
                  q_iv[i] = q_iv[i+1];
                  q_id[i] = q_id[i+1];
               end
               q_cnt--;
               push_rsp(stq_pkg::ST_CANCELLED, d, 0, 1);
            end else push_rsp(stq_pkg::ST_NOT_FOUND, d, 0, 1);
         end
         stq_pkg::REQ_TICK: begin
            while (n < q_cnt && q_exp[n] < tm) begin
               xid[n] = q_id[n];
               xiv[n] = q_iv[n];
               n++;
            end
            for (int i = 0; i + n < q_cnt; i++) begin
               q_exp[i] = q_exp[i+n];
               q_iv[i] = q_iv[i+n];
               q_id[i] = q_id[i+n];
            end
            q_cnt -= n;
            for (int i = 0; i < n; i++)
               if (xiv[i] != 0) begin
                  sum = {1'b0, tm} + xiv[i];
                  if (sum[TIME_W]) sum[TIME_W-1:0] = TIME_MAX;
                  if (insert_timer(sum[TIME_W-1:0], xiv[i], xid[i])) front = 1;
               end
            for (int i = 0; i < n; i++) push_rsp(stq_pkg::ST_EXPIRED, xid[i], 0, 0);
            push_rsp(stq_pkg::ST_TICK_DONE, '0, front, 1);
         end
         default: begin
            // unused code, ignored
         end
      endcase
   endfunction

   // request transfers feed the model, response transfers are compared
   always @(posedge clock) begin
      timer_rsp_type w;
      if (reset) begin
         q_cnt = 0;
         wr_ptr = 0;
         rd_ptr = 0;
         fail_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (wr_ptr == rd_ptr) begin
               $display("%0t: unexpected response status=%0d id=%0h", $time,
                        rsp_status, rsp_out_id);
               fail_count <= fail_count + 1;
            end else begin
               w = rsp_ring[rd_ptr % RING_LEN];
               rd_ptr++;
               if (w != {rsp_status, rsp_out_id, rsp_head_changed, rsp_next_expiry,
                         rsp_queue_empty, rsp_last}) begin
                  $display("%0t: mismatch expected st=%0d id=%h hc=%b nx=%h em=%b ls=%b",
                           $time, w.status, w.out_id, w.head_changed, w.next_expiry,
                           w.queue_empty, w.last);
                  $display("%0t:          actual st=%0d id=%h hc=%b nx=%h em=%b ls=%b",
                           $time, rsp_status, rsp_out_id, rsp_head_changed,
                           rsp_next_expiry, rsp_queue_empty, rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            predict_request(req_type, req_timer_id, req_expire_time, req_interval_us);
      end
   end
endmodule
`default_nettype wire

FILE: bench/tb_sorted_timer_queue.sv
`default_nettype none
module tb_sorted_timer_queue;

   localparam int TIME_W = stq_pkg::TIME_W;
   localparam int IV_W = stq_pkg::IV_W;
   localparam int ID_W = stq_pkg::ID_W;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_type;
   logic [ID_W-1:0] req_timer_id;
   logic [TIME_W-1:0] req_expire_time;
   logic [IV_W-1:0] req_interval_us;
   logic rsp_strobe;
   logic [2:0] rsp_status;
   logic [ID_W-1:0] rsp_out_id;
   logic rsp_head_changed;
   logic [TIME_W-1:0] rsp_next_expiry;
   logic rsp_queue_empty;
   logic rsp_last;
   int fail_count;
   int pending_count;
   int cycle_count = 0;
   logic [TIME_W-1:0] now_us;

   localparam int CYCLE_LIMIT = 400000;

   sorted_timer_queue DUT (.*);

   stq_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one request transfer, start held until accepted; the gap lowers start
   task automatic send_request(logic [1:0] t, logic [ID_W-1:0] d,
                               logic [TIME_W-1:0] e, logic [IV_W-1:0] v);
      start <= 1;
      req_type <= t;
      req_timer_id <= d;
      req_expire_time <= e;
      req_interval_us <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap();
      int g;
      g = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(2, 0);
      if (g > 0) start <= 0;
      repeat (g) @(posedge clock);
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      return ($urandom_range(3, 0) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(7, 0));
   endfunction

   initial begin
      logic [1:0] t;
      logic [TIME_W-1:0] e;
      logic [IV_W-1:0] v;
      reset = 1;
      start = 0;
      req_type = stq_pkg::REQ_NONE;
      req_timer_id = '0;
      req_expire_time = '0;
      req_interval_us = '0;
      now_us = 48'd1000;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty cases, unused code, extremes, full queue, overflow
      send_request(stq_pkg::REQ_TICK, '0, '1, '0);
      send_request(stq_pkg::REQ_CANCEL, 16'hffff, '0, '0);
      send_request(stq_pkg::REQ_NONE, 16'h1234, '1, '1);
      send_request(stq_pkg::REQ_ADD, 16'hffff, '1, '1);
      send_request(stq_pkg::REQ_ADD, 16'h0000, '0, '0);
      send_request(stq_pkg::REQ_ADD, 16'h0005, 48'd100, 32'd0);
      send_request(stq_pkg::REQ_ADD, 16'h0006, 48'd100, 32'hffffffff);
      send_request(stq_pkg::REQ_CANCEL, 16'h0005, '0, '0);
      for (int i = 0; i < 14; i++)
         send_request(stq_pkg::REQ_ADD, ID_W'(i + 8), 48'd50, 32'd7);
      send_request(stq_pkg::REQ_ADD, 16'haaaa, 48'd1, 32'd1);
      send_request(stq_pkg::REQ_TICK, '0, 48'hfffffffffff0, '0);
      send_request(stq_pkg::REQ_TICK, '0, '1, '0);

      // random: mostly adds and ticks around a moving now
      for (int n = 0; n < 204; n++) begin
         idle_gap();
         t = 2'($urandom_range(99, 0) < 45 ? stq_pkg::REQ_ADD :
               $urandom_range(99, 0) < 55 ? stq_pkg::REQ_TICK :
               $urandom_range(9, 0) == 0 ? stq_pkg::REQ_NONE : stq_pkg::REQ_CANCEL);
         v = $urandom_range(3, 0) == 0 ? 32'd0 :
             $urandom_range(19, 0) == 0 ? IV_W'($urandom) : IV_W'($urandom_range(200, 1));
         e = $urandom_range(19, 0) == 0 ? TIME_W'({$urandom, $urandom}) :
             now_us + $urandom_range(300, 0);
         if (t == stq_pkg::REQ_TICK) begin
            now_us = now_us + $urandom_range(150, 0);
            e = ($urandom_range(29, 0) == 0) ? TIME_W'({$urandom, $urandom}) : now_us;
         end
         send_request(t, pick_id(), e, v);
      end
      start <= 0;

      do @(posedge clock); while (pending_count != 0 || busy);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sorted_timer_queue.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_ram.sv
hw/rtl/stq_cells.sv
hw/rtl/sorted_timer_queue.sv
bench/stq_checker.sv
bench/tb_sorted_timer_queue.sv
